/* src/rlwt_pkg.sv */
// Shared types and constants for the round-trip loss window tracker.
package rlwt_pkg;

   localparam int TIME_W     = 24;     // round-trip time in microseconds
   localparam int LOSS_OUT_W = 5;      // reported loss count
   localparam int PCT_W      = 14;     // loss rate in hundredths of a percent
   localparam int SCALE_W    = 14;

   localparam logic [SCALE_W-1:0]    LOSS_SCALE   = 14'd10000;
   localparam logic [LOSS_OUT_W-1:0] LOSS_OUT_MAX = 5'd31;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_LOSS   = 1'b1
   } op_type;

   // One window slot: loss flag plus time (time is zero for a loss).
   typedef struct packed {
      logic              loss;
      logic [TIME_W-1:0] rtt;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_OUT
   } state_type;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic start;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

/* src/rlwt_cell.sv */
// One window slot; takes its upstream neighbor's entry when the chain shifts.
module rlwt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  rlwt_pkg::entry_type d,
   output rlwt_pkg::entry_type q
);
   import rlwt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift ? d : entry_ff;
   end

   // Reset state is a zero-time sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule

/* src/rlwt_div.sv */
// Restoring serial divider: one quotient bit per cycle.
module rlwt_div #(
   parameter int DIV_W = 28,
   parameter int DEN_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rlwt_pkg::div_req_type req,
   input  logic [DIV_W-1:0]      dividend,
   input  logic [DEN_W-1:0]      divisor,
   output rlwt_pkg::div_sts_type sts,
   output logic [DIV_W-1:0]      quotient
);
   import rlwt_pkg::*;

   localparam int STEP_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] rem_shift;
   logic [DEN_W:0] rem_sub;
   logic           take;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      take      = rem_shift >= {1'b0, den_ff};
      rem_sub   = rem_shift - {1'b0, den_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (req.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_LAST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so DEN_W bits hold it
         quo_in = {quo_ff[DIV_W-2:0], take};
         rem_in = take ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/rtt_loss_window_tracker.sv */
// Top level: sliding window of round-trip events with mean and loss statistics.
//
// Each request beat is one event (a measured round trip or a lost reply). The
// window is a ring of WINDOW_SIZE cells; a new event pushes in at the head and
// the oldest one drops off the tail. After reset every slot holds a zero-time
// sample. One response beat follows every request beat, carrying the truncated
// mean of the non-lost slots (zero when all are lost), the loss count
// (saturating at 31) and the loss rate in hundredths of a percent. For each
// event the ring rotates once past the accumulator, one slot per cycle, then a
// start state launches the one-bit-per-cycle divider for the mean, and the
// result is loaded into the output register once that register is free.
// DIV_W is TIME_W + clog2(WINDOW_SIZE). The loss rate comes from a constant
// table indexed by the loss count. req_stall is high while an event is being
// worked on, and also while a finished event waits for a stalled output
// register; a response held in the output register does not block the next
// request.
module rtt_loss_window_tracker #(
   parameter int WINDOW_SIZE = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [rlwt_pkg::TIME_W-1:0]   req_rtt_us,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rlwt_pkg::TIME_W-1:0]   rsp_mean_rtt_us,
   output logic [rlwt_pkg::LOSS_OUT_W-1:0] rsp_loss_count,
   output logic [rlwt_pkg::PCT_W-1:0]    rsp_loss_hundredths_percent
);
   import rlwt_pkg::*;

   // counts run 0..WINDOW_SIZE
   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int IDX_W  = $clog2(WINDOW_SIZE);
   localparam int SUM_W  = TIME_W + $clog2(WINDOW_SIZE);
   localparam int DIV_W  = SUM_W;
   localparam int EXT_W  = CNT_W + LOSS_OUT_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);

   state_type state_ff, state_in;

   // ---------------------------------------------------------------------
   // Window ring
   // ---------------------------------------------------------------------
   entry_type cell_d [WINDOW_SIZE];
   entry_type cell_q [WINDOW_SIZE];
   entry_type new_entry;
   logic      req_accept;
   logic      ring_shift;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   // a loss stores the flag with a zero time
   always_comb begin
      new_entry.loss = (req_operation == OP_LOSS);
      new_entry.rtt  = (req_operation == OP_LOSS) ? '0 : req_rtt_us;
   end

   // new event pushes at the head; during the scan the ring rotates tail->head
   assign ring_shift = req_accept || (state_ff == ST_SCAN);
   assign cell_d[0]  = req_accept ? new_entry : cell_q[WINDOW_SIZE-1];

   genvar gi;
   generate
      for (gi = 1; gi < WINDOW_SIZE; gi++) begin : g_link
         assign cell_d[gi] = cell_q[gi-1];
      end
      for (gi = 0; gi < WINDOW_SIZE; gi++) begin : g_cell
         rlwt_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring_shift),
            .d     (cell_d[gi]),
            .q     (cell_q[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Scan accumulators (fed from the tail cell)
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] samples_ff, samples_in;
   logic [CNT_W-1:0] losses_ff, losses_in;
   entry_type        tail;

   assign tail = cell_q[WINDOW_SIZE-1];

   always_comb begin
      scan_in    = scan_ff;
      sum_in     = sum_ff;
      samples_in = samples_ff;
      losses_in  = losses_ff;
      if (req_accept) begin
         scan_in    = '0;
         sum_in     = '0;
         samples_in = '0;
         losses_in  = '0;
      end else if (state_ff == ST_SCAN) begin
         scan_in = scan_ff + 1'b1;
         if (tail.loss) begin
            losses_in = losses_ff + 1'b1;
         end else begin
            samples_in = samples_ff + 1'b1;
            sum_in     = sum_ff + SUM_W'(tail.rtt);
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      sum_ff     <= sum_in;
      samples_ff <= samples_in;
      losses_ff  <= losses_in;
   end

   // ---------------------------------------------------------------------
   // Divider for the mean: sum / samples
   // ---------------------------------------------------------------------
   div_req_type      div_req;
   div_sts_type      div_sts;
   logic [DIV_W-1:0] div_num;
   logic [CNT_W-1:0] div_den;
   logic [DIV_W-1:0] div_quo;

   assign div_num = sum_ff;
   assign div_den = samples_ff;

   rlwt_div #(
      .DIV_W (DIV_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (div_num),
      .divisor  (div_den),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------
   // Loss rate: losses * 10000 / size, one constant per possible count
   // ---------------------------------------------------------------------
   logic [PCT_W-1:0] pct_val;

   always_comb begin
      pct_val = '0;
      for (int i = 0; i <= WINDOW_SIZE; i++) begin
         if (losses_ff == CNT_W'(i)) begin
            pct_val = PCT_W'((i * int'(LOSS_SCALE)) / WINDOW_SIZE);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result holding and output register
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0]     mean_ff, mean_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]     rsp_mean_ff, rsp_mean_in;
   logic [LOSS_OUT_W-1:0] rsp_loss_ff, rsp_loss_in;
   logic [PCT_W-1:0]      rsp_pct_ff, rsp_pct_in;
   logic [EXT_W-1:0]      loss_ext;
   logic [LOSS_OUT_W-1:0] loss_sat;
   logic                  out_free;

   // loss count saturates at 31 for windows above that size
   assign loss_ext = EXT_W'(losses_ff);
   assign loss_sat = (loss_ext > EXT_W'(LOSS_OUT_MAX)) ? LOSS_OUT_MAX
                                                       : loss_ext[LOSS_OUT_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      div_req.start = 1'b0;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mean_in   = rsp_mean_ff;
      rsp_loss_in   = rsp_loss_ff;
      rsp_pct_in    = rsp_pct_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == IDX_LAST) begin
               state_in = ST_MEAN_START;
            end
         end
         ST_MEAN_START: begin
            div_req.start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_sts.done) begin
               // every slot lost: mean is zero
               mean_in  = (samples_ff == '0) ? '0 : div_quo[TIME_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_loss_in  = loss_sat;
               rsp_pct_in   = pct_val;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff     <= mean_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_loss_ff <= rsp_loss_in;
      rsp_pct_ff  <= rsp_pct_in;
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_mean_rtt_us             = rsp_mean_ff;
   assign rsp_loss_count              = rsp_loss_ff;
   assign rsp_loss_hundredths_percent = rsp_pct_ff;

endmodule
